[src/pac_pkg.sv]
// Package: widths, register indexes, codes and reset values of the proximity alert controller.
package pac_pkg;

	localparam int CNT_W  = 16;
	localparam int CM_W   = 10;
	localparam int ECHO_W = 16;
	localparam int DIST_W = 14;
	localparam int BAT_W  = 7;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int D_W    = 21;
	localparam int MM_W   = 20;
	localparam int RCP_SH = 27;

	localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
	localparam logic [4:0]        ECHO_SCALE  = 5'd17;
	localparam logic [9:0]        CM_SCALE    = 10'd1000;
	localparam logic [D_W-1:0]    RCP_100     = 21'd1342178;
	localparam logic [BAT_W-1:0]  BAT_FULL    = 7'd100;
	localparam logic [BAT_W-1:0]  BAT_LOW_LIM = 7'd20;

	localparam logic [CNT_W-1:0] RST_DEBOUNCE = 16'd50;
	localparam logic [CNT_W-1:0] RST_MEASURE  = 16'd500;
	localparam logic [CNT_W-1:0] RST_SCREEN   = 16'd2000;
	localparam logic [CNT_W-1:0] RST_BATTERY  = 16'd30000;
	localparam logic [CM_W-1:0]  RST_MIN_CM   = 10'd2;
	localparam logic [CM_W-1:0]  RST_MAX_CM   = 10'd400;
	localparam logic [CM_W-1:0]  RST_SAFE_CM  = 10'd100;
	localparam logic [CM_W-1:0]  RST_DANGER_CM = 10'd40;

	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE = 3'd0,
		REG_MEASURE  = 3'd1,
		REG_SCREEN   = 3'd2,
		REG_BATTERY  = 3'd3,
		REG_MIN_CM   = 3'd4,
		REG_MAX_CM   = 3'd5,
		REG_SAFE_CM  = 3'd6,
		REG_DANGER_CM = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		LED_NONE   = 2'd0,
		LED_GREEN  = 2'd1,
		LED_YELLOW = 2'd2,
		LED_RED    = 2'd3
	} led_t;

	typedef enum logic [1:0] {
		ZONE_OUT     = 2'd0,
		ZONE_SAFE    = 2'd1,
		ZONE_WARNING = 2'd2,
		ZONE_DANGER  = 2'd3
	} zone_t;

	typedef enum logic [1:0] {
		SCR_OFF    = 2'd0,
		SCR_DIST   = 2'd1,
		SCR_STATUS = 2'd2
	} screen_t;

endpackage

[src/proximity_alert_controller.sv]
// Top level: proximity alert controller, one tick item in, one status item out.
// Each accepted item passes the input register, then the output register, when not stalled.
// Throughput: one item per cycle while out_stall is low; the input register feeds a single
// pass of compare and counter logic that updates the state and loads the output register.
// in_stall rises only when both registers hold an item and the output is stalled.
// Reset: asynchronous, clears control and state to the power-up values (system on).
module proximity_alert_controller
	import pac_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              button_level,
	input  logic [ECHO_W-1:0] echo_us,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              sys_active,
	output logic              trigger,
	output logic [1:0]        led_code,
	output logic [1:0]        zone,
	output logic [DIST_W-1:0] distance_tenths,
	output logic [BAT_W-1:0]  battery_percent,
	output logic              battery_low,
	output logic [1:0]        screen_shown
);

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	// configuration
	logic [CNT_W-1:0] debounce_ticks_q, measure_period_q, screen_period_q, battery_period_q;
	logic [CM_W-1:0]  min_cm_q, max_cm_q, safe_cm_q, danger_cm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= RST_DEBOUNCE;
			measure_period_q <= RST_MEASURE;
			screen_period_q  <= RST_SCREEN;
			battery_period_q <= RST_BATTERY;
			min_cm_q         <= RST_MIN_CM;
			max_cm_q         <= RST_MAX_CM;
			safe_cm_q        <= RST_SAFE_CM;
			danger_cm_q      <= RST_DANGER_CM;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE:  debounce_ticks_q <= cfg_data;
				REG_MEASURE:   measure_period_q <= cfg_data;
				REG_SCREEN:    screen_period_q  <= cfg_data;
				REG_BATTERY:   battery_period_q <= cfg_data;
				REG_MIN_CM:    min_cm_q         <= cfg_data[CM_W-1:0];
				REG_MAX_CM:    max_cm_q         <= cfg_data[CM_W-1:0];
				REG_SAFE_CM:   safe_cm_q        <= cfg_data[CM_W-1:0];
				REG_DANGER_CM: danger_cm_q      <= cfg_data[CM_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic valid_s1;
	logic advance;
	logic in_take;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && out_valid && out_stall;
	assign in_take  = in_valid && !in_stall;

	// input register: echo already scaled to thousandths of a cm
	logic           level_s1;
	logic [D_W-1:0] d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			level_s1 <= button_level;
			d_s1     <= D_W'(echo_us) * D_W'(ECHO_SCALE);
		end
	end

	// state
	logic              prev_level_q, stable_level_q, is_on_q, screen_flip_q;
	logic [CNT_W-1:0]  debounce_count_q, measure_count_q, screen_count_q, battery_count_q;
	logic [BAT_W-1:0]  battery_level_q;
	logic [1:0]        led_state_q, last_zone_q, screen_state_q;
	logic [DIST_W-1:0] last_distance_q;

	logic              stable_n, is_on_n, flip_n, trig_n;
	logic [CNT_W-1:0]  deb_n, meas_n, scr_n, bat_cnt_n;
	logic [BAT_W-1:0]  bat_n;
	logic [1:0]        led_n, zone_n, screen_n;
	logic [DIST_W-1:0] dist_n;
	logic [2*D_W-1:0]  quot_prod;
	logic [D_W-1:0]    min_mm, max_mm, safe_mm, danger_mm;

	assign quot_prod = d_s1 * RCP_100;
	assign min_mm    = D_W'(MM_W'(min_cm_q) * MM_W'(CM_SCALE));
	assign max_mm    = D_W'(MM_W'(max_cm_q) * MM_W'(CM_SCALE));
	assign safe_mm   = D_W'(MM_W'(safe_cm_q) * MM_W'(CM_SCALE));
	assign danger_mm = D_W'(MM_W'(danger_cm_q) * MM_W'(CM_SCALE));

	always_comb begin
		stable_n  = stable_level_q;
		is_on_n   = is_on_q;
		flip_n    = screen_flip_q;
		screen_n  = screen_state_q;
		trig_n    = 1'b0;
		led_n     = led_state_q;
		zone_n    = last_zone_q;
		dist_n    = last_distance_q;
		bat_n     = battery_level_q;

		// debounce and toggle
		deb_n = (level_s1 != prev_level_q) ? '0 : sat_inc(debounce_count_q);
		if (deb_n > debounce_ticks_q && level_s1 != stable_level_q) begin
			stable_n = level_s1;
			if (!level_s1) begin
				if (!is_on_q) begin
					is_on_n  = 1'b1;
					flip_n   = 1'b0;
					screen_n = SCR_DIST;
				end else begin
					is_on_n  = 1'b0;
					screen_n = SCR_OFF;
				end
			end
		end

		// battery
		bat_cnt_n = sat_inc(battery_count_q);
		if (bat_cnt_n >= battery_period_q) begin
			bat_cnt_n = '0;
			if (battery_level_q != '0)
				bat_n = battery_level_q - 1'b1;
		end

		// measurement
		meas_n = sat_inc(measure_count_q);
		if (!is_on_n) begin
			led_n = LED_NONE;
		end else if (meas_n >= measure_period_q) begin
			meas_n = '0;
			trig_n = 1'b1;
			if (d_s1 < min_mm || d_s1 > max_mm) begin
				led_n  = LED_NONE;
				zone_n = ZONE_OUT;
			end else if (d_s1 > safe_mm) begin
				led_n  = LED_GREEN;
				zone_n = ZONE_SAFE;
			end else if (d_s1 > danger_mm) begin
				led_n  = LED_YELLOW;
				zone_n = ZONE_WARNING;
			end else begin
				led_n  = LED_RED;
				zone_n = ZONE_DANGER;
			end
			dist_n = quot_prod[RCP_SH+DIST_W-1:RCP_SH];
		end

		// screen
		scr_n = sat_inc(screen_count_q);
		if (is_on_n && scr_n >= screen_period_q) begin
			scr_n    = '0;
			flip_n   = !flip_n;
			screen_n = flip_n ? SCR_DIST : SCR_STATUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q     <= 1'b1;
			stable_level_q   <= 1'b1;
			debounce_count_q <= '0;
			is_on_q          <= 1'b1;
			measure_count_q  <= '0;
			screen_count_q   <= '0;
			battery_count_q  <= '0;
			battery_level_q  <= BAT_FULL;
			screen_flip_q    <= 1'b0;
			led_state_q      <= LED_NONE;
			last_zone_q      <= ZONE_OUT;
			last_distance_q  <= '0;
			screen_state_q   <= SCR_DIST;
		end else if (advance) begin
			prev_level_q     <= level_s1;
			stable_level_q   <= stable_n;
			debounce_count_q <= deb_n;
			is_on_q          <= is_on_n;
			measure_count_q  <= meas_n;
			screen_count_q   <= scr_n;
			battery_count_q  <= bat_cnt_n;
			battery_level_q  <= bat_n;
			screen_flip_q    <= flip_n;
			led_state_q      <= led_n;
			last_zone_q      <= zone_n;
			last_distance_q  <= dist_n;
			screen_state_q   <= screen_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sys_active      <= is_on_n;
			trigger         <= trig_n;
			led_code        <= led_n;
			zone            <= zone_n;
			distance_tenths <= dist_n;
			battery_percent <= bat_n;
			battery_low     <= (bat_n < BAT_LOW_LIM);
			screen_shown    <= screen_n;
		end
	end

endmodule
